>>> src/lgs_pkg.sv
// lgs_pkg: payload structs, configuration struct and shared codes for the
// leg grounding sequencer. No dependencies; used by lgs_core and the top level.
`timescale 1ns / 1ps

package lgs_pkg;

  // Input item: start command or one control step
  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic        stats_valid;
    logic [31:0] pitch_spread;
    logic [31:0] roll_spread;
  } lgs_in_t;

  // Result item: one per input item
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] extend_mask;
    logic       stop_all;
    logic       stop_one_valid;
    logic [1:0] stop_one_index;
  } lgs_out_t;

  // Configuration registers as seen by the core
  typedef struct packed {
    logic [31:0] ground_threshold;
    logic [15:0] ground_hold_ms;
    logic [15:0] pair_switch_ms;
    logic [15:0] settle_delay_ms;
  } lgs_cfg_t;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 32;

  // Register indexes
  localparam logic [CfgIndexW-1:0] CFG_GROUND_THRESHOLD = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_GROUND_HOLD_MS   = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_PAIR_SWITCH_MS   = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_SETTLE_DELAY_MS  = 2'd3;

  // Register reset values (threshold is 0.0010 in Q8.24)
  localparam logic [31:0] RST_GROUND_THRESHOLD = 32'd16777;
  localparam logic [15:0] RST_GROUND_HOLD_MS   = 16'd500;
  localparam logic [15:0] RST_PAIR_SWITCH_MS   = 16'd8000;
  localparam logic [15:0] RST_SETTLE_DELAY_MS  = 16'd8000;

  // Input actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_MOVING = 2'd0;
  localparam logic [1:0] STATUS_DONE   = 2'd1;
  localparam logic [1:0] STATUS_ERROR  = 2'd2;

endpackage

>>> src/lgs_core.sv
// lgs_core: sequencer state and the single-pass step logic of the leg
// grounding sequencer. Depends on lgs_pkg.
`timescale 1ns / 1ps

module lgs_core #(
  parameter int LEG_COUNT  = 4,
  parameter int PAIR_COUNT = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  lgs_pkg::lgs_cfg_t cfg,
  input  lgs_pkg::lgs_in_t  in_item,
  output lgs_pkg::lgs_out_t result
);

  localparam int PairSize = LEG_COUNT / PAIR_COUNT;
  localparam int CntW     = $clog2(LEG_COUNT + 1);
  localparam int PairW    = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PAIR   = 3'd1;
  localparam logic [2:0] PH_SINGLE = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;
  localparam logic [2:0] PH_ERROR  = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic             seen_r, seen_nxt;
  logic [31:0]      ground_since_r, ground_since_nxt;
  logic [31:0]      pair_since_r, pair_since_nxt;
  logic [31:0]      settle_since_r, settle_since_nxt;
  logic [PairW-1:0] pair_r, pair_nxt;
  logic [CntW-1:0]  leg_r, leg_nxt;
  logic [CntW-1:0]  count_r, count_nxt;

  logic             spread_hi;
  logic             seen_chk;
  logic [31:0]      since_chk;
  logic             confirm;
  logic             settle_ok;
  logic             pair_expired;
  logic [3:0]       pair_mask;
  logic [3:0]       single_mask;
  logic [31:0]      pair_lo;
  logic [PairW-1:0] pair_inc;
  logic [CntW-1:0]  count_inc;

  // Ground tracking as it would stand after this step's check
  always_comb begin
    spread_hi = (in_item.pitch_spread >= cfg.ground_threshold) ||
                (in_item.roll_spread >= cfg.ground_threshold);
    seen_chk  = seen_r | spread_hi;
    since_chk = (spread_hi && !seen_r) ? in_item.now_ms : ground_since_r;
    confirm   = seen_chk && ((in_item.now_ms - since_chk) >= {16'd0, cfg.ground_hold_ms});
    settle_ok = (in_item.now_ms - settle_since_r) >= {16'd0, cfg.settle_delay_ms};
    pair_expired = (in_item.now_ms - pair_since_r) > {16'd0, cfg.pair_switch_ms};
  end

  // Leg masks; legs beyond the four visible bits are dropped
  always_comb begin
    pair_lo = 32'(pair_r) * 32'(PairSize);
    for (int b = 0; b < 4; b++) begin
      pair_mask[b]   = (32'(b) >= pair_lo) && (32'(b) < pair_lo + 32'(PairSize));
      single_mask[b] = (32'(leg_r) == 32'(b));
    end
    pair_inc  = (32'(pair_r) == 32'(PAIR_COUNT - 1)) ? '0 : pair_r + 1'b1;
    count_inc = count_r + 1'b1;
  end

  always_comb begin
    phase_nxt        = phase_r;
    seen_nxt         = seen_r;
    ground_since_nxt = ground_since_r;
    pair_since_nxt   = pair_since_r;
    settle_since_nxt = settle_since_r;
    pair_nxt         = pair_r;
    leg_nxt          = leg_r;
    count_nxt        = count_r;
    result           = '0;

    if (in_item.action == lgs_pkg::ACT_START) begin
      // Start: enter pair mode from any phase
      phase_nxt        = PH_PAIR;
      seen_nxt         = 1'b0;
      pair_nxt         = '0;
      leg_nxt          = '0;
      count_nxt        = '0;
      pair_since_nxt   = in_item.now_ms;
      settle_since_nxt = '0;
      result.status    = lgs_pkg::STATUS_MOVING;
    end else begin
      unique case (phase_r)
        PH_PAIR: begin
          result.status = lgs_pkg::STATUS_MOVING;
          if (settle_ok) begin
            result.extend_mask = pair_mask;
            if (!in_item.stats_valid) begin
              phase_nxt = PH_ERROR;
            end else begin
              seen_nxt         = seen_chk;
              ground_since_nxt = since_chk;
              if (confirm) begin
                phase_nxt        = PH_SINGLE;
                seen_nxt         = 1'b0;
                result.stop_all  = 1'b1;
                settle_since_nxt = in_item.now_ms;
              end else if (pair_expired) begin
                result.stop_all = 1'b1;
                pair_nxt        = pair_inc;
                pair_since_nxt  = in_item.now_ms;
              end
            end
          end
        end
        PH_SINGLE: begin
          result.status = lgs_pkg::STATUS_MOVING;
          if (settle_ok) begin
            result.extend_mask = single_mask;
            if (!in_item.stats_valid) begin
              phase_nxt = PH_ERROR;
            end else begin
              seen_nxt         = seen_chk;
              ground_since_nxt = since_chk;
              if (confirm) begin
                result.stop_one_valid = 1'b1;
                result.stop_one_index = leg_r[1:0];
                seen_nxt              = 1'b0;
                leg_nxt               = leg_r + 1'b1;
                count_nxt             = count_inc;
                if (32'(count_inc) >= 32'(LEG_COUNT)) begin
                  phase_nxt = PH_DONE;
                end else begin
                  settle_since_nxt = in_item.now_ms;
                end
              end
            end
          end
        end
        PH_DONE: begin
          result.status = lgs_pkg::STATUS_DONE;
        end
        default: begin
          // Idle and error both report error and take no action
          result.status = lgs_pkg::STATUS_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      seen_r         <= 1'b0;
      ground_since_r <= '0;
      pair_since_r   <= '0;
      settle_since_r <= '0;
      pair_r         <= '0;
      leg_r          <= '0;
      count_r        <= '0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      seen_r         <= seen_nxt;
      ground_since_r <= ground_since_nxt;
      pair_since_r   <= pair_since_nxt;
      settle_since_r <= settle_since_nxt;
      pair_r         <= pair_nxt;
      leg_r          <= leg_nxt;
      count_r        <= count_nxt;
    end
  end

endmodule

>>> src/leg_grounding_sequencer.sv
// leg_grounding_sequencer: top level with configuration registers, handshake
// and two-entry result buffer. Depends on lgs_pkg and lgs_core.
`timescale 1ns / 1ps

// Usage
//   in_valid / in_ready / in_data carry start commands and control steps; each
//   transfer yields exactly one result on out_valid / out_ready / out_data.
//   cfg_we / cfg_index / cfg_wdata write one of the four setup registers per write
//   (threshold, hold time, pair switch time, settle delay); write them only
//   while no result is outstanding.
// Throughput
//   A step is worked out in the cycle of its transfer; its result is registered
//   in the output register or, behind a waiting result, in the skid entry. With
//   in_ready high one item per cycle is taken, bounded by the step logic.
// Stalls
//   A result register and a skid entry sit behind the step logic, so one more
//   item is taken while a result waits; in_ready drops only once both are
//   full and rises again as soon as the receiver takes a result.
// Reset
//   rst_n (synchronous) returns the sequencer to idle, loads the register
//   defaults and empties the result buffer. Steps before a start report error.

module leg_grounding_sequencer #(
  parameter int LEG_COUNT  = 4,
  parameter int PAIR_COUNT = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lgs_pkg::lgs_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lgs_pkg::lgs_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [lgs_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [lgs_pkg::CfgDataW-1:0]        cfg_wdata
);

  lgs_pkg::lgs_cfg_t cfg_r, cfg_nxt;
  lgs_pkg::lgs_out_t step_res;
  lgs_pkg::lgs_out_t out_r, out_nxt;
  lgs_pkg::lgs_out_t skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic              in_xfer;
  logic              out_xfer;

  // Take a new item whenever the skid entry is free
  assign in_ready  = !skid_valid_r;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lgs_pkg::CFG_GROUND_THRESHOLD: cfg_nxt.ground_threshold = cfg_wdata;
        lgs_pkg::CFG_GROUND_HOLD_MS:   cfg_nxt.ground_hold_ms   = cfg_wdata[15:0];
        lgs_pkg::CFG_PAIR_SWITCH_MS:   cfg_nxt.pair_switch_ms   = cfg_wdata[15:0];
        lgs_pkg::CFG_SETTLE_DELAY_MS:  cfg_nxt.settle_delay_ms  = cfg_wdata[15:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  // Sequencer state and step logic; state advances on each input transfer
  lgs_core #(
    .LEG_COUNT  (LEG_COUNT),
    .PAIR_COUNT (PAIR_COUNT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_xfer),
    .cfg     (cfg_r),
    .in_item (in_data),
    .result  (step_res)
  );

  // Result buffer: output register first, skid entry behind it
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_xfer) begin
      // Output slot is free this cycle: refill from skid, else from the step
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (in_xfer) begin
        out_nxt       = step_res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      // Receiver stalls: park the new result in the skid entry
      skid_nxt       = step_res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ground_threshold <= lgs_pkg::RST_GROUND_THRESHOLD;
      cfg_r.ground_hold_ms   <= lgs_pkg::RST_GROUND_HOLD_MS;
      cfg_r.pair_switch_ms   <= lgs_pkg::RST_PAIR_SWITCH_MS;
      cfg_r.settle_delay_ms  <= lgs_pkg::RST_SETTLE_DELAY_MS;
      out_valid_r            <= 1'b0;
      skid_valid_r           <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // A transfer while the receiver stalls must land in the skid entry
  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("result lost while receiver stalled");

  // A transfer into an empty buffer shows up on the output next cycle
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !out_valid_r) |=> (out_valid_r && !skid_valid_r))
    else $error("result not presented after transfer into empty buffer");

  // Whole-set stop and single-leg stop belong to different phases
  a_stop_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.stop_all && out_r.stop_one_valid))
    else $error("stop_all and stop_one_valid reported together");
`endif

endmodule
